[design/urbc_pkg.sv]
// ----------------------------------------------------------------------------
// urbc_pkg
// Shared types and constants of the ultrasonic range band controller.
// ----------------------------------------------------------------------------
`default_nettype none

package urbc_pkg;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_TRIGGER_TICKS = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_HOLDOFF_TICKS = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_SCALE_Q16     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_FAR_CM        = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NEAR_CM       = 3'd4;

	// register field widths
	localparam int TRIG_W  = 10;
	localparam int HOLD_W  = 14;
	localparam int SCALE_W = 16;

	// distance
	localparam int DIST_W = 12;
	localparam logic [DIST_W-1:0] DIST_MAX = 12'hFFF;

	// stream widths
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 24;
	localparam int M_TUSER_W = 1;

	typedef enum logic [1:0] {
		BAND_NONE = 2'd0,
		BAND_FAR  = 2'd1,
		BAND_MID  = 2'd2,
		BAND_NEAR = 2'd3
	} band_t;

endpackage

`default_nettype wire

[design/urbc_range.sv]
// ----------------------------------------------------------------------------
// urbc_range
// Echo count to distance in whole cm (Q16 scale, saturated) and band select.
// ----------------------------------------------------------------------------
`default_nettype none

module urbc_range
	import urbc_pkg::*;
#(
	parameter int COUNT_BITS = 16
) (
	input  wire logic [COUNT_BITS-1:0] echo_count,
	input  wire logic [SCALE_W-1:0]    scale_q16,
	input  wire logic [DIST_W-1:0]     far_cm,
	input  wire logic [DIST_W-1:0]     near_cm,
	output logic      [DIST_W-1:0]     distance,
	output band_t                      band
);

	localparam int PROD_W = COUNT_BITS + SCALE_W;

	logic [PROD_W-1:0]     prod;
	logic [COUNT_BITS-1:0] whole_cm;

	assign prod     = PROD_W'(echo_count) * PROD_W'(scale_q16);
	// drop the fraction
	assign whole_cm = prod[PROD_W-1:SCALE_W];

	always_comb begin
		if (whole_cm > COUNT_BITS'(DIST_MAX)) begin
			distance = DIST_MAX;
		end else begin
			distance = whole_cm[DIST_W-1:0];
		end
		// far wins when thresholds cross
		if (distance >= far_cm) begin
			band = BAND_FAR;
		end else if (distance >= near_cm) begin
			band = BAND_MID;
		end else begin
			band = BAND_NEAR;
		end
	end

endmodule

`default_nettype wire

[design/ultrasonic_range_band_controller_core.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_band_controller_core
// Tick-driven echo ranging controller with three distance bands.
//
// Usage:
//   Feed one item per 1 us tick on the slave stream; s_tdata[0] is the sampled
//   echo level. Every accepted item yields exactly one item on the master
//   stream: the trigger level for that tick, the motor and LED lines of the
//   current band, the last distance and a flag that marks the tick on which a
//   new distance and band take effect.
//   Each measurement drives trigger low, high, low (trigger_ticks each), waits
//   for echo, counts echo-high ticks, waits holdoff_ticks and then updates the
//   distance (count * scale_q16 >> 16, capped at 4095) and the band.
//   An item passes the input register, then the result register, before it
//   leaves. Throughput: one item per clock while the master does not stall.
//   A stalled master holds its item; the slave still takes one more item into
//   the input register and then deasserts s_tready until the output drains.
//   Reset clears the pipeline, starts at the first trigger low segment with
//   all motor lines and LEDs off, distance 0, and loads default registers.
//   Registers are written through cfg_we/cfg_index/cfg_wdata; the user must
//   write them only while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module ultrasonic_range_band_controller_core
	import urbc_pkg::*;
#(
	parameter int COUNT_BITS = 16,
	parameter int TIMER_BITS = 14
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// slave stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [S_TDATA_W-1:0]  s_tdata,   // [0] echo, [7:1] zero
	// master stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// [0] trigger, [1] motor_forward, [2] motor_backward, [3] led_green,
	// [4] led_yellow, [5] led_red, [17:6] distance_cm, [23:18] zero
	output logic      [M_TDATA_W-1:0]  m_tdata,
	output logic      [M_TUSER_W-1:0]  m_tuser,   // [0] distance_valid
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam int HCMP_W = (TIMER_BITS > HOLD_W) ? TIMER_BITS : HOLD_W;
	localparam int PAD_W  = M_TDATA_W - DIST_W - 6;

	typedef enum logic [2:0] {
		PH_TRIG_LOW_A = 3'd0,
		PH_TRIG_HIGH  = 3'd1,
		PH_TRIG_LOW_B = 3'd2,
		PH_WAIT_ECHO  = 3'd3,
		PH_COUNT      = 3'd4,
		PH_HOLDOFF    = 3'd5
	} phase_t;

	// configuration registers
	logic [TRIG_W-1:0]  trigger_ticks_q;
	logic [HOLD_W-1:0]  holdoff_ticks_q;
	logic [SCALE_W-1:0] scale_q16_q;
	logic [DIST_W-1:0]  far_cm_q;
	logic [DIST_W-1:0]  near_cm_q;

	// input register
	logic valid_s1;
	logic echo_s1;

	// measurement state
	phase_t                phase_q;
	logic [TIMER_BITS-1:0] phase_timer_q;
	logic [COUNT_BITS-1:0] echo_count_q;
	band_t                 band_q;
	logic [DIST_W-1:0]     last_distance_q;

	// result register
	logic                 valid_s2;
	logic [M_TDATA_W-1:0] data_s2;
	logic                 dvalid_s2;

	// next-state logic
	phase_t                phase_d;
	logic [TIMER_BITS-1:0] timer_d;
	logic [COUNT_BITS-1:0] count_d;
	band_t                 band_d;
	logic [DIST_W-1:0]     dist_d;
	logic                  trig;
	logic                  hold;
	logic                  finish;

	logic [TIMER_BITS-1:0] timer_base;
	logic [TIMER_BITS-1:0] timer_inc;
	logic                  timer_sat;
	logic                  trig_done;
	logic                  hold_done;

	logic [DIST_W-1:0] calc_dist;
	band_t             calc_band;

	logic advance;
	logic step;

	// advance when the result register is free or drains this cycle
	assign advance  = !valid_s2 || m_tready;
	assign step     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = dvalid_s2;

	// configuration writes; unknown indexes drop
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trigger_ticks_q <= TRIG_W'(10);
			holdoff_ticks_q <= HOLD_W'(10000);
			scale_q16_q     <= SCALE_W'(2228);
			far_cm_q        <= DIST_W'(550);
			near_cm_q       <= DIST_W'(450);
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TRIGGER_TICKS: trigger_ticks_q <= cfg_wdata[TRIG_W-1:0];
				REG_HOLDOFF_TICKS: holdoff_ticks_q <= cfg_wdata[HOLD_W-1:0];
				REG_SCALE_Q16:     scale_q16_q     <= cfg_wdata[SCALE_W-1:0];
				REG_FAR_CM:        far_cm_q        <= cfg_wdata[DIST_W-1:0];
				REG_NEAR_CM:       near_cm_q       <= cfg_wdata[DIST_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// hold the echo sample until the step logic takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			echo_s1  <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
			echo_s1  <= s_tdata[0];
		end
	end

	urbc_range #(
		.COUNT_BITS (COUNT_BITS)
	) u_range (
		.echo_count (echo_count_q),
		.scale_q16  (scale_q16_q),
		.far_cm     (far_cm_q),
		.near_cm    (near_cm_q),
		.distance   (calc_dist),
		.band       (calc_band)
	);

	// holdoff entered from the count phase starts from a cleared timer
	assign timer_base = (phase_q == PH_COUNT) ? '0 : phase_timer_q;
	assign timer_sat  = (timer_base == TIMER_MAX);
	assign timer_inc  = timer_sat ? TIMER_MAX : timer_base + TIMER_BITS'(1);
	// zero trigger length acts as one; a saturated timer ends the segment
	assign trig_done  = (timer_inc >= TIMER_BITS'(trigger_ticks_q)) ||
	                    (timer_inc == TIMER_MAX);
	assign hold_done  = (HCMP_W'(timer_inc) >= HCMP_W'(holdoff_ticks_q)) ||
	                    (timer_inc == TIMER_MAX);

	always_comb begin
		phase_d = phase_q;
		timer_d = phase_timer_q;
		count_d = echo_count_q;
		band_d  = band_q;
		dist_d  = last_distance_q;
		trig    = 1'b0;
		hold    = 1'b0;
		finish  = 1'b0;

		case (phase_q)
			PH_TRIG_LOW_A: begin
				if (trig_done) begin
					phase_d = PH_TRIG_HIGH;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_TRIG_HIGH: begin
				trig = 1'b1;
				if (trig_done) begin
					phase_d = PH_TRIG_LOW_B;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_TRIG_LOW_B: begin
				if (trig_done) begin
					phase_d = PH_WAIT_ECHO;
					timer_d = '0;
				end else begin
					timer_d = timer_inc;
				end
			end
			PH_WAIT_ECHO: begin
				// no timeout: wait here for the echo to rise
				if (echo_s1) begin
					count_d = COUNT_BITS'(1);
					phase_d = PH_COUNT;
					timer_d = '0;
				end
			end
			PH_COUNT: begin
				if (echo_s1) begin
					if (echo_count_q != COUNT_MAX) begin
						count_d = echo_count_q + COUNT_BITS'(1);
					end
				end else begin
					// falling tick is holdoff tick one
					hold = 1'b1;
				end
			end
			PH_HOLDOFF: begin
				hold = 1'b1;
			end
			default: begin
				phase_d = PH_TRIG_LOW_A;
				timer_d = '0;
			end
		endcase

		if (hold) begin
			if (hold_done) begin
				finish  = 1'b1;
				band_d  = calc_band;
				dist_d  = calc_dist;
				phase_d = PH_TRIG_LOW_A;
				timer_d = '0;
			end else begin
				phase_d = PH_HOLDOFF;
				timer_d = timer_inc;
			end
		end
	end

	// advance state and load the result item, one tick per step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q         <= PH_TRIG_LOW_A;
			phase_timer_q   <= '0;
			echo_count_q    <= '0;
			band_q          <= BAND_NONE;
			last_distance_q <= '0;
			valid_s2        <= 1'b0;
			data_s2         <= '0;
			dvalid_s2       <= 1'b0;
		end else begin
			if (advance) begin
				valid_s2 <= valid_s1;
			end
			if (step) begin
				phase_q         <= phase_d;
				phase_timer_q   <= timer_d;
				echo_count_q    <= count_d;
				band_q          <= band_d;
				last_distance_q <= dist_d;
				// new band and distance show on the tick they take effect
				data_s2 <= {{PAD_W{1'b0}}, dist_d,
				            band_d == BAND_NEAR, band_d == BAND_MID,
				            band_d == BAND_FAR, band_d == BAND_NEAR,
				            band_d == BAND_FAR, trig};
				dvalid_s2 <= finish;
			end
		end
	end

endmodule

`default_nettype wire

[design/urbc_checker.sv]
// ----------------------------------------------------------------------------
// urbc_checker
// Port-level checks of the ultrasonic range band controller.
// ----------------------------------------------------------------------------
`default_nettype none

module urbc_checker
	import urbc_pkg::*;
(
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 s_tvalid,
	input wire logic                 s_tready,
	input wire logic                 m_tvalid,
	input wire logic                 m_tready,
	input wire logic [M_TDATA_W-1:0] m_tdata,
	input wire logic [M_TUSER_W-1:0] m_tuser
);

	// a stalled item holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output item changed while stalled");

	// motor and LED lines follow one band
	a_band_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[5:3]) && (m_tdata[1] == m_tdata[3]) &&
		             (m_tdata[2] == m_tdata[5]))
		else $error("motor and LED lines disagree");

	// trigger is low on the tick a result takes effect
	a_valid_trig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> !m_tdata[0])
		else $error("trigger high on result tick");

	// an output item that appears from empty was taken in on the slave stream earlier
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
		else $error("output item without input item");

endmodule

bind ultrasonic_range_band_controller_core urbc_checker u_urbc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

[test/urbc_checker.sv]
// ----------------------------------------------------------------------------
// urbc_checker
// Watches the tick and result streams of the range band controller, keeps its
// own copy of the measurement cycle and compares every result item with the
// predicted one, field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module urbc_scoreboard
	import urbc_pkg::*;
#(
	parameter int COUNT_BITS = 16,
	parameter int TIMER_BITS = 14
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	input  logic                  s_tready,
	input  logic [S_TDATA_W-1:0]  s_tdata,
	input  logic                  m_tvalid,
	input  logic                  m_tready,
	input  logic [M_TDATA_W-1:0]  m_tdata,
	input  logic [M_TUSER_W-1:0]  m_tuser,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_wdata,
	output int                    fail_count,
	output int                    pending
);

	typedef enum logic [2:0] {
		ST_LEAD_LOW,
		ST_PULSE,
		ST_TAIL_LOW,
		ST_WAIT_ECHO,
		ST_ECHO,
		ST_HOLDOFF
	} ping_state_t;

	typedef struct packed {
		logic              trigger;
		logic              fwd;
		logic              bwd;
		logic              green;
		logic              yellow;
		logic              red;
		logic [DIST_W-1:0] dist_cm;
		logic              fresh;
	} tick_out_t;

	localparam logic [TIMER_BITS-1:0] TIMER_TOP = '1;
	localparam logic [COUNT_BITS-1:0] COUNT_TOP = '1;

	logic [TRIG_W-1:0]     trig_len;
	logic [HOLD_W-1:0]     hold_len;
	logic [SCALE_W-1:0]    scale;
	logic [DIST_W-1:0]     far_th;
	logic [DIST_W-1:0]     near_th;

	ping_state_t           state;
	logic [TIMER_BITS-1:0] timer;
	logic [COUNT_BITS-1:0] echo_cnt;
	band_t                 band;
	logic [DIST_W-1:0]     dist_val;

	tick_out_t             tick_q[$];
	int                    result_idx;

	function automatic logic [TIMER_BITS-1:0] timer_inc();
		return (timer == TIMER_TOP) ? TIMER_TOP : timer + 1'b1;
	endfunction

	function automatic void end_segment(input ping_state_t nxt);
		logic [TIMER_BITS-1:0] t;
		t = timer_inc();
		if (t >= trig_len || t == TIMER_TOP) begin
			state = nxt;
			timer = '0;
		end else begin
			timer = t;
		end
	endfunction

	// One holdoff tick; at its end latch distance and band and restart.
	function automatic logic holdoff_step();
		logic [TIMER_BITS-1:0] t;
		longint unsigned       prod;
		t = timer_inc();
		if (t >= hold_len || t == TIMER_TOP) begin
			prod = longint'(echo_cnt) * longint'(scale);
			prod = prod >> 16;
			dist_val = (prod > longint'(DIST_MAX)) ? DIST_MAX : prod[DIST_W-1:0];
			if (dist_val >= far_th)
				band = BAND_FAR;
			else if (dist_val >= near_th)
				band = BAND_MID;
			else
				band = BAND_NEAR;
			state = ST_LEAD_LOW;
			timer = '0;
			return 1'b1;
		end
		timer = t;
		return 1'b0;
	endfunction

	function automatic tick_out_t range_tick(input logic echo);
		tick_out_t r;
		logic      pulse;
		logic      fresh;
		pulse = 1'b0;
		fresh = 1'b0;
		case (state)
			ST_LEAD_LOW: end_segment(ST_PULSE);
			ST_PULSE: begin
				pulse = 1'b1;
				end_segment(ST_TAIL_LOW);
			end
			ST_TAIL_LOW: end_segment(ST_WAIT_ECHO);
			ST_WAIT_ECHO: begin
				if (echo) begin
					echo_cnt = COUNT_BITS'(1);
					state = ST_ECHO;
					timer = '0;
				end
			end
			ST_ECHO: begin
				if (echo) begin
					if (echo_cnt != COUNT_TOP)
						echo_cnt = echo_cnt + 1'b1;
				end else begin
					state = ST_HOLDOFF;
					timer = '0;
					fresh = holdoff_step();
				end
			end
			ST_HOLDOFF: fresh = holdoff_step();
			default: begin
				state = ST_LEAD_LOW;
				timer = '0;
			end
		endcase
		r.trigger = pulse;
		r.fwd     = (band == BAND_FAR);
		r.bwd     = (band == BAND_NEAR);
		r.green   = (band == BAND_FAR);
		r.yellow  = (band == BAND_MID);
		r.red     = (band == BAND_NEAR);
		r.dist_cm = dist_val;
		r.fresh   = fresh;
		return r;
	endfunction

	// Cap the printout; every mismatch still counts.
	task automatic report_mismatch(input string msg);
		if (fail_count < 100)
			$display("ERROR @%0t: %s", $realtime, msg);
		fail_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report_mismatch($sformatf("result %0d %s: got %0d, want %0d",
				result_idx, name, got, want));
	endtask

	always @(posedge clk or negedge arst_n) begin
		tick_out_t got;
		tick_out_t want;
		if (!arst_n) begin
			trig_len   = TRIG_W'(10);
			hold_len   = HOLD_W'(10000);
			scale      = SCALE_W'(2228);
			far_th     = DIST_W'(550);
			near_th    = DIST_W'(450);
			state      = ST_LEAD_LOW;
			timer      = '0;
			echo_cnt   = '0;
			band       = BAND_NONE;
			dist_val   = '0;
			tick_q.delete();
			result_idx = 0;
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_TRIGGER_TICKS: trig_len = cfg_wdata[TRIG_W-1:0];
					REG_HOLDOFF_TICKS: hold_len = cfg_wdata[HOLD_W-1:0];
					REG_SCALE_Q16:     scale    = cfg_wdata[SCALE_W-1:0];
					REG_FAR_CM:        far_th   = cfg_wdata[DIST_W-1:0];
					REG_NEAR_CM:       near_th  = cfg_wdata[DIST_W-1:0];
					default: ;
				endcase
			end
			if (m_tvalid && m_tready) begin
				got.trigger = m_tdata[0];
				got.fwd     = m_tdata[1];
				got.bwd     = m_tdata[2];
				got.green   = m_tdata[3];
				got.yellow  = m_tdata[4];
				got.red     = m_tdata[5];
				got.dist_cm = m_tdata[17:6];
				got.fresh   = m_tuser[0];
				if (tick_q.size() == 0) begin
					report_mismatch($sformatf("result %0d arrived with none expected",
						result_idx));
				end else begin
					want = tick_q.pop_front();
					check_field("trigger", got.trigger, want.trigger);
					check_field("motor_forward", got.fwd, want.fwd);
					check_field("motor_backward", got.bwd, want.bwd);
					check_field("led_green", got.green, want.green);
					check_field("led_yellow", got.yellow, want.yellow);
					check_field("led_red", got.red, want.red);
					check_field("distance_cm", got.dist_cm, want.dist_cm);
					check_field("distance_valid", got.fresh, want.fresh);
				end
				result_idx++;
			end
			if (s_tvalid && s_tready)
				tick_q.push_back(range_tick(s_tdata[0]));
			pending = tick_q.size();
		end
	end

endmodule

[test/ultrasonic_range_band_controller_core_tb.sv]
// ----------------------------------------------------------------------------
// ultrasonic_range_band_controller_core_tb
// Drives echo ticks and register settings into the range band controller and
// gives the verdict; a checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ultrasonic_range_band_controller_core_tb;
	import urbc_pkg::*;

	localparam int COUNT_BITS   = 16;
	localparam int TIMER_BITS   = 14;
	localparam int CYCLE_LIMIT  = 1000000;
	// let the input and result registers drain before touching registers
	localparam int DRAIN_CYCLES = 4;
	localparam int RAND_TICKS   = 900;
	// the long receiver hold-off starts once this many ticks have gone in
	localparam int PRESS_AT     = 400;
	localparam int PRESS_CYCLES = 200;

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [S_TDATA_W-1:0]  s_tdata;   // [0] echo, [7:1] zero
	logic                  m_tvalid;
	logic                  m_tready;
	// [0] trigger, [1] motor_forward, [2] motor_backward, [3] led_green,
	// [4] led_yellow, [5] led_red, [17:6] distance_cm, [23:18] zero
	logic [M_TDATA_W-1:0]  m_tdata;
	logic [M_TUSER_W-1:0]  m_tuser;   // [0] distance_valid
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_wdata;

	int fail_count;
	int pending;
	int cycle_count;
	int ticks_sent;
	bit steady;       // no idling on either side while set
	bit press_done;

	// stimulus-side mirror of the lengths that shape a measurement cycle
	int cur_trig;
	int cur_hold;

	ultrasonic_range_band_controller_core #(
		.COUNT_BITS(COUNT_BITS),
		.TIMER_BITS(TIMER_BITS)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

	urbc_scoreboard #(
		.COUNT_BITS(COUNT_BITS),
		.TIMER_BITS(TIMER_BITS)
	) u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Mostly short gaps, now and then a long one.
	function automatic int idle_len();
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 40);
		return $urandom_range(1, 3);
	endfunction

	function automatic logic coin();
		return $urandom_range(0, 1) != 0;
	endfunction

	// Offer one tick item; hold it until taken, then maybe idle for a while.
	task automatic send_tick(input logic echo);
		int gap;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= {{(S_TDATA_W-1){1'b0}}, echo};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		ticks_sent++;
		if (!steady && $urandom_range(0, 99) < 25) begin
			gap = idle_len();
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// Drop valid, wait for every expected result, then let the pipe empty.
	task automatic settle();
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (pending == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= CFG_DATA_W'(val);
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic set_config(input int trig, input int hold, input int scale,
			input int far, input int near);
		write_reg(REG_TRIGGER_TICKS, trig);
		write_reg(REG_HOLDOFF_TICKS, hold);
		write_reg(REG_SCALE_Q16, scale);
		write_reg(REG_FAR_CM, far);
		write_reg(REG_NEAR_CM, near);
		cur_trig = trig;
		cur_hold = hold;
	endtask

	// One full measurement cycle: trigger segments (echo ignored there), a quiet
	// wait, the echo pulse, then the holdoff ending on the result tick. With
	// from_wait set the block is already waiting for echo.
	task automatic run_ping(input int echo_len, input int wait_len, input bit noisy,
			input bit from_wait);
		int lead;
		int tail;
		lead = from_wait ? 0 : 3 * ((cur_trig == 0) ? 1 : cur_trig);
		tail = (cur_hold == 0) ? 1 : cur_hold;
		repeat (lead) send_tick(noisy ? coin() : 1'b0);
		repeat (wait_len) send_tick(1'b0);
		repeat (echo_len) send_tick(1'b1);
		// falling echo opens the holdoff; later holdoff ticks ignore echo
		send_tick(1'b0);
		repeat (tail - 1) send_tick(noisy ? coin() : 1'b0);
	endtask

	// Receiver: random stalls, plus one long hold-off so the block backs up.
	initial begin
		int stall_left;
		stall_left = 0;
		press_done = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_left > 0) begin
				stall_left--;
				m_tready <= 1'b0;
			end else if (!press_done && !steady && ticks_sent >= PRESS_AT) begin
				press_done = 1'b1;
				stall_left = PRESS_CYCLES - 1;
				m_tready <= 1'b0;
			end else if (!steady && $urandom_range(0, 99) < 20) begin
				stall_left = idle_len() - 1;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Watchdog: end the run if it hangs.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("TEST FAILED");
		$finish;
	end

	initial begin
		int rand_goal;
		int trig;
		int hold;
		int scale;
		int far;
		int near;
		arst_n     = 1'b0;
		s_tvalid   = 1'b0;
		s_tdata    = '0;
		cfg_we     = 1'b0;
		cfg_index  = '0;
		cfg_wdata  = '0;
		steady     = 1'b0;
		ticks_sent = 0;
		cur_trig   = 10;
		cur_hold   = 10000;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: unused indexes, zero trigger length, zero holdoff, full
		// scale, then pings in each band near the thresholds.
		write_reg(3'd5, 0);
		write_reg(3'd7, 16'hFFFF);
		set_config(0, 0, 16'hFFFF, 3, 2);
		run_ping(1, 0, 1'b0, 1'b0);  // distance 0, near band
		run_ping(2, 0, 1'b1, 1'b0);  // distance 1, near band
		run_ping(3, 1, 1'b0, 1'b0);  // distance 2, middle band
		run_ping(5, 0, 1'b1, 1'b0);  // distance 4, far band

		// Random: short cycles, many settings, some broken sequences.
		rand_goal = ticks_sent + RAND_TICKS;
		while (ticks_sent < rand_goal) begin
			settle();
			if ($urandom_range(0, 3) == 0)
				write_reg(CFG_IDX_W'($urandom_range(5, 7)), $urandom_range(0, 65535));
			trig = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
			hold = $urandom_range(0, 6);
			case ($urandom_range(0, 3))
				0: scale = 0;
				1: scale = 16'hFFFF;
				default: scale = $urandom_range(0, 65535);
			endcase
			far  = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 48);
			near = ($urandom_range(0, 7) == 0) ? 4095 : $urandom_range(0, 48);
			set_config(trig, hold, scale, far, near);
			repeat ($urandom_range(3, 8)) begin
				if ($urandom_range(0, 99) < 15) begin
					// broken sequence, then enough low ticks to land in the echo wait
					repeat ($urandom_range(1, 12)) send_tick(coin());
					repeat (((hold == 0) ? 1 : hold) + 3 * ((trig == 0) ? 1 : trig))
						send_tick(1'b0);
					run_ping($urandom_range(1, 48), $urandom_range(0, 4), coin(), 1'b1);
				end else begin
					run_ping($urandom_range(1, 48), $urandom_range(0, 4), coin(), 1'b0);
				end
			end
		end

		// Longer segments and holdoff, run without idling to keep the run short.
		settle();
		steady = 1'b1;
		// top thresholds put the result in the near band
		set_config(64, 160, 16'hFFFF, 4095, 4095);
		run_ping(20, 2, 1'b1, 1'b0);
		settle();
		steady = 1'b0;

		if (fail_count == 0 && pending == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
